>>> rtl/hdlc_zero_bit_stuffer_macros.svh
// assertion macros for the hdlc zero-bit stuffer
`ifndef HDLC_ZERO_BIT_STUFFER_MACROS_SVH
`define HDLC_ZERO_BIT_STUFFER_MACROS_SVH

// property must hold at every clock edge outside reset
`define HZBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define HZBS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/hzbs_pkg.sv
// shared types, constants and the per-octet stuffing function
`default_nettype none

package hzbs_pkg;

    localparam int RUN_LIMIT   = 5;
    localparam int BYTE_BITS   = 8;
    localparam int STUFF_MAX   = 10;
    localparam int LEN_W       = 4;
    localparam int RUN_W       = 3;
    localparam int ACC_W       = 17;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one octet after zero insertion, earliest bit in bit 0
    typedef struct packed {
        logic [STUFF_MAX-1:0] bits;
        logic [LEN_W-1:0]     len;
    } stuffed_t;

    typedef struct packed {
        stuffed_t         item;
        logic [RUN_W-1:0] run;
    } stuff_result_t;

    function automatic stuff_result_t stuff_octet(input logic [BYTE_BITS-1:0] data,
                                                  input logic [RUN_W-1:0] run_in);
        stuff_result_t    r;
        logic [RUN_W-1:0] run;
        logic [LEN_W-1:0] pos;
        r   = '0;
        run = (run_in >= RUN_W'(RUN_LIMIT)) ? '0 : run_in;
        pos = '0;
        for (int i = 0; i < BYTE_BITS; i++) begin
            r.item.bits[pos] = data[i];
            pos = pos + LEN_W'(1);
            if (data[i]) begin
                if (run == RUN_W'(RUN_LIMIT - 1)) begin
                    // inserted zero, bit already clear
                    pos = pos + LEN_W'(1);
                    run = '0;
                end
                else begin
                    run = run + RUN_W'(1);
                end
            end
            else begin
                run = '0;
            end
        end
        r.item.len = pos;
        r.run      = run;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hzbs_front.sv
// front end: accepts octets, inserts zeros, tracks the run of ones
`default_nettype none

module hzbs_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [hzbs_pkg::BYTE_BITS-1:0] data_octet,
    output logic                              full,
    input  wire logic                         q_full,
    output logic                              q_push,
    output hzbs_pkg::stuffed_t                q_item
);
    import hzbs_pkg::*;

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    stuff_result_t    stuffed;

    always_comb
    begin
        stuffed  = stuff_octet(data_octet, run_reg);
        full     = q_full;
        q_push   = push && !q_full;
        q_item   = stuffed.item;
        run_next = q_push ? stuffed.run : run_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hzbs_queue.sv
// short queue of stuffed octets between front and back
`default_nettype none

module hzbs_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire hzbs_pkg::stuffed_t wr_item,
    output logic             q_full,
    input  wire logic        rd_en,
    output hzbs_pkg::stuffed_t rd_item,
    output logic             q_empty
);
    import hzbs_pkg::*;

    stuffed_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        q_full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        q_empty     = (count_reg == '0);
        rd_item     = mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hzbs_back.sv
// back end: packs stuffed bits into bytes and drives the output register
`default_nettype none

module hzbs_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_empty,
    input  wire hzbs_pkg::stuffed_t             q_item,
    output logic                                q_pop,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [hzbs_pkg::BYTE_BITS-1:0]      line_byte,
    output logic                                last_of_run
);
    import hzbs_pkg::*;

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [BYTE_BITS-1:0] byte_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 out_room;
    logic                 emit;
    logic [ACC_W-1:0]     acc_shift;
    logic [CNT_W-1:0]     cnt_shift;

    always_comb
    begin
        out_room  = !out_valid_reg || pop;
        emit      = (cnt_reg >= CNT_W'(BYTE_BITS)) && out_room;
        acc_shift = emit ? (acc_reg >> BYTE_BITS) : acc_reg;
        cnt_shift = emit ? (cnt_reg - CNT_W'(BYTE_BITS)) : cnt_reg;
        // take the next octet once no full byte remains
        q_pop     = !q_empty && (cnt_shift < CNT_W'(BYTE_BITS));
        acc_next  = acc_shift;
        cnt_next  = cnt_shift;
        if (q_pop)
        begin
            acc_next = acc_shift | (ACC_W'(q_item.bits) << cnt_shift[RUN_W-1:0]);
            cnt_next = cnt_shift + CNT_W'(q_item.len);
        end
        out_valid_next = emit || (out_valid_reg && !pop);
        byte_next      = emit ? acc_reg[BYTE_BITS-1:0] : byte_reg;
        // last byte of an octet leaves fewer than a byte behind
        last_next      = emit ? (cnt_reg < CNT_W'(2 * BYTE_BITS)) : last_reg;
        empty          = !out_valid_reg;
        line_byte      = byte_reg;
        last_of_run    = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

>>> rtl/hdlc_zero_bit_stuffer.sv
// HDLC zero-bit insertion: octets in, packed line bytes out, LSB first.
// The front stuffs each accepted octet in the cycle it arrives and writes it
// into a two-entry queue; the back merges it with the residual bits and puts
// one byte per cycle in the output register while that register has room. Each
// completed byte leaves through the single byte output register, and the front
// keeps accepting octets while the queue is not full. The first byte of an
// octet passes from the queue through the accumulator into the output register.
// Residual bits (fewer than 8) wait for later octets; flags, CRC and flushing
// are handled outside.
`default_nettype none

`include "hdlc_zero_bit_stuffer_macros.svh"

module hdlc_zero_bit_stuffer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [hzbs_pkg::BYTE_BITS-1:0]   data_octet,
    input  wire logic                             pop,
    output logic                                  empty,
    output logic [hzbs_pkg::BYTE_BITS-1:0]        line_byte,
    output logic                                  last_of_run
);
    import hzbs_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    stuffed_t q_wr_item;
    stuffed_t q_rd_item;

    hzbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_octet (data_octet),
        .full       (full),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_wr_item)
    );

    hzbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .q_empty (q_empty)
    );

    hzbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_rd_item),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .line_byte   (line_byte),
        .last_of_run (last_of_run)
    );

    // every accepted transaction lands in the queue
    `HZBS_ASSERT(a_push_fills_queue, (push && !full) |=> !q_empty, "accepted octet missing from queue")
    `HZBS_NEVER(a_no_push_when_full, q_push && q_full, "queue written while full")
    `HZBS_NEVER(a_no_pop_when_empty, q_pop && q_empty, "queue read while empty")
    // stuffed length is always between one byte and the maximum
    `HZBS_NEVER(a_len_range, q_push && (q_wr_item.len < LEN_W'(BYTE_BITS) || q_wr_item.len > LEN_W'(STUFF_MAX)), "bad stuffed length")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the hdlc zero-bit stuffer: scoreboard class, drivers and checks
`default_nettype none

module tb;

    import hzbs_pkg::BYTE_BITS;
    import hzbs_pkg::RUN_LIMIT;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 488;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [BYTE_BITS-1:0] line_byte;
        logic                 last_of_run;
    } line_word_t;

    class stuffed_byte_checker;
        line_word_t           want_bytes[$];
        logic [2:0]           run_of_ones;
        logic [6:0]           residue;
        logic [2:0]           residue_len;
        int                   errors;
        int                   octets_seen;
        int                   bytes_seen;
        int                   zeros_inserted;
        int                   double_octets;

        function new();
            run_of_ones    = '0;
            residue        = '0;
            residue_len    = '0;
            errors         = 0;
            octets_seen    = 0;
            bytes_seen     = 0;
            zeros_inserted = 0;
            double_octets  = 0;
        endfunction

        function void report(string msg);
            if (errors < 20)
                $display("tb: mismatch: %s", msg);
            errors++;
        endfunction

        // stuff one octet onto the residue and queue every full byte it completes
        function void note_octet(logic [BYTE_BITS-1:0] octet);
            logic [16:0] acc;
            int          cnt;
            int          run;
            int          n;
            line_word_t  w;
            cnt = residue_len;
            acc = 17'(residue) & ((17'd1 << cnt) - 17'd1);
            run = (run_of_ones >= RUN_LIMIT) ? 0 : run_of_ones;
            n   = 0;
            for (int i = 0; i < BYTE_BITS; i++)
            begin
                acc[cnt] = octet[i];
                cnt++;
                if (octet[i])
                begin
                    run++;
                    if (run == RUN_LIMIT)
                    begin
                        // stuffed zero, bit already clear
                        cnt++;
                        run = 0;
                        zeros_inserted++;
                    end
                end
                else
                begin
                    run = 0;
                end
            end
            while (cnt >= BYTE_BITS && n < 2)
            begin
                w.line_byte   = acc[7:0];
                w.last_of_run = 1'b0;
                want_bytes.push_back(w);
                acc = acc >> BYTE_BITS;
                cnt -= BYTE_BITS;
                n++;
            end
            if (n > 0)
                want_bytes[want_bytes.size()-1].last_of_run = 1'b1;
            if (n == 2)
                double_octets++;
            run_of_ones = 3'(run);
            residue_len = 3'(cnt);
            residue     = 7'(acc & ((17'd1 << (cnt & 7)) - 17'd1));
            octets_seen++;
        endfunction

        function void check_byte(logic [BYTE_BITS-1:0] got_byte, logic got_last);
            line_word_t w;
            if (want_bytes.size() == 0)
            begin
                report($sformatf("line byte %h with no octet waiting", got_byte));
                return;
            end
            w = want_bytes.pop_front();
            bytes_seen++;
            if (got_byte !== w.line_byte)
                report($sformatf("byte %0d: line_byte %h, want %h",
                                 bytes_seen, got_byte, w.line_byte));
            if (got_last !== w.last_of_run)
                report($sformatf("byte %0d: last_of_run %b, want %b",
                                 bytes_seen, got_last, w.last_of_run));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [BYTE_BITS-1:0] data_octet;
    logic                 pop;
    logic                 empty;
    logic [BYTE_BITS-1:0] line_byte;
    logic                 last_of_run;

    int                   sender_idle_pct;
    int                   recv_stall_pct;
    int                   cycle_count;

    stuffed_byte_checker  board = new();

    hdlc_zero_bit_stuffer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_octet  (data_octet),
        .pop         (pop),
        .empty       (empty),
        .line_byte   (line_byte),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // both transaction kinds are seen with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_octet(data_octet);
            if (pop && !empty)
                board.check_byte(line_byte, last_of_run);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_octet(input logic [BYTE_BITS-1:0] octet);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        data_octet <= octet;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // long runs of ones dominate so the stuffing path is hit often
    function automatic logic [BYTE_BITS-1:0] random_octet();
        logic [BYTE_BITS-1:0] edge_octets[8];
        edge_octets = '{8'hFF, 8'h1F, 8'hF8, 8'h7E, 8'h3E, 8'hF0, 8'h0F, 8'hFE};
        case ($urandom_range(9))
            0, 1, 2, 3: return BYTE_BITS'($urandom);
            4, 5:       return 8'hFF;
            6:          return BYTE_BITS'($urandom | $urandom | $urandom);
            7:          return edge_octets[$urandom_range(7)];
            8:          return 8'h00;
            default:    return 8'hFF ^ (8'h01 << $urandom_range(7));
        endcase
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (PHASE_ITEMS)
            send_octet(random_octet());
    endtask

    initial
    begin
        logic [BYTE_BITS-1:0] directed[$];
        rst_n           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        data_octet      = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes, runs of ones across octets, fifth one on the last bit
        directed = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'hF8, 8'h00, 8'hF8,
                     8'h7E, 8'h3E, 8'h01, 8'h80, 8'h55, 8'hAA, 8'hF0, 8'h0F,
                     8'hFE, 8'h7F, 8'hBF, 8'hFF, 8'h00, 8'hFF, 8'hEF, 8'hF7};
        foreach (directed[k])
            send_octet(directed[k]);

        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(22, 22);
        push           <= 1'b0;
        recv_stall_pct  = 0;

        while (board.want_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.want_bytes.size() != 0)
            board.report($sformatf("%0d line bytes never arrived", board.want_bytes.size()));

        $display("tb: %0d octets in, %0d line bytes checked over four idling mixes",
                 board.octets_seen, board.bytes_seen);
        $display("tb: %0d zeros stuffed, %0d octets gave two bytes, %0d mismatches",
                 board.zeros_inserted, board.double_octets, board.errors);
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
